// ===== hdl/hdf_pkg.sv =====
// ----------------------------------------------------------------------------
// hdf_pkg
// Shared types and constants for the despike filter.
// ----------------------------------------------------------------------------
`default_nettype none
package hdf_pkg;
   localparam int unsigned SigmaQ16 = 97164;
   localparam int unsigned KBits = 16;
   localparam int unsigned WinBits = 5;
   localparam logic [0:0] CsrWindow = 1'b0;
   localparam logic [0:0] CsrK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SORT,
      ST_DEV,
      ST_SORT2,
      ST_TEST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic sort;
      logic odd;
      logic dev;
   } cell_ctl_type;
endpackage
`default_nettype wire

// ===== hdl/hdf_sort_cell.sv =====
// ----------------------------------------------------------------------------
// hdf_sort_cell
// One cell of the odd-even transposition sorter: holds one value and swaps
// with its right neighbor on its phase.
// ----------------------------------------------------------------------------
`default_nettype none
module hdf_sort_cell #(
   parameter int unsigned DataBits = 33
) (
   input  wire                       clock,
   input  wire hdf_pkg::cell_ctl_type ctl,
   input  wire                       active_phase,
   input  wire                       is_unsigned,
   input  wire  [DataBits-1:0]       load_value,
   input  wire  [DataBits-1:0]       dev_value,
   input  wire  [DataBits-1:0]       left_value,
   input  wire  [DataBits-1:0]       right_value,
   input  wire                       has_left,
   input  wire                       has_right,
   input  wire                       left_phase,
   output logic [DataBits-1:0]       value
);
   logic [DataBits-1:0] value_ff, value_in;
   logic                gt_right, gt_left;

   always_comb begin
      if (is_unsigned) begin
         gt_right = value_ff > right_value;
         gt_left  = left_value > value_ff;
      end else begin
         gt_right = $signed(value_ff) > $signed(right_value);
         gt_left  = $signed(left_value) > $signed(value_ff);
      end
      value_in = value_ff;
      if (ctl.load) begin
         value_in = load_value;
      end else if (ctl.dev) begin
         value_in = dev_value;
      end else if (ctl.sort) begin
         // pair with right when this cell starts the pair, else with left
         if (active_phase && has_right && gt_right) begin
            value_in = right_value;
         end else if (left_phase && has_left && gt_left) begin
            value_in = left_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule
`default_nettype wire

// ===== hdl/hampel_despike_filter_unit.sv =====
// ----------------------------------------------------------------------------
// hampel_despike_filter_unit
// Streaming median / MAD despike filter over spectrum bins.
// ----------------------------------------------------------------------------
// Each accepted word is stored in a small history row; every bin that becomes
// ready is filtered through a row of sorting cells (odd-even transposition):
// load, n phases for the median, absolute deviations, n phases for the MAD,
// the threshold test and the write back, with n the window width set by the
// window register. Old bins are dropped from the history one at a time while
// idle, and the last word of a spectrum flushes up to r+1 bins. A result
// word waiting on the output holds the next bin in its test state.
`default_nettype none
module hampel_despike_filter_unit #(
   parameter int unsigned MAX_WINDOW  = 17,
   parameter int unsigned SAMPLE_BITS = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [SAMPLE_BITS-1:0]  req_tdata,   // sample_in
   input  wire                     req_tlast,   // last_in
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [SAMPLE_BITS-1:0]  rsp_tdata,   // sample_out
   output logic                    rsp_tuser,   // replaced
   output logic                    rsp_tlast,   // last_out
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [0:0]              csr_index,
   input  wire  [15:0]             csr_data
);
   localparam int unsigned IdxBits = $clog2(MAX_WINDOW + 1);
   localparam int unsigned PosBits = $clog2(MAX_WINDOW);
   localparam int unsigned DBits   = SAMPLE_BITS + 1;
   localparam int unsigned WMax    = (MAX_WINDOW - 1) | 1;
   localparam int unsigned RMax    = WMax / 2;
   localparam int unsigned KsBits  = hdf_pkg::KBits + 17;
   localparam int unsigned ProdBits = hdf_pkg::KBits + 17 + DBits;

   hdf_pkg::state_type state_ff, state_in;
   logic [4:0]               win_ff;
   logic [15:0]              k_ff;
   logic [SAMPLE_BITS-1:0]   hist_ff [MAX_WINDOW];
   logic [IdxBits-1:0]       seen_ff, seen_in;
   logic [IdxBits-1:0]       pos_ff, pos_in;
   logic                     last_ff, last_in;
   logic                     run_ff, run_in;
   logic [IdxBits-1:0]       phase_ff, phase_in;
   logic [SAMPLE_BITS-1:0]   med_ff;
   logic [KsBits-1:0]        kmul_ff;
   logic [ProdBits-1:0]      thr_ff;
   logic [ProdBits-1:0]      lhs_ff;
   logic [SAMPLE_BITS-1:0]   out_data_ff;
   logic                     out_rep_ff, out_last_ff, out_valid_ff;
   logic [IdxBits-1:0]       rad;
   logic [IdxBits-1:0]       nwin;
   logic [DBits-1:0]         cell_val [MAX_WINDOW];
   logic [DBits-1:0]         cell_load [MAX_WINDOW];
   logic [DBits-1:0]         cell_dev [MAX_WINDOW];
   logic [DBits-1:0]         mid_cell;
   hdf_pkg::cell_ctl_type    ctl;
   logic                     accept, pending, is_last_bin, drop;
   logic [SAMPLE_BITS-1:0]   centre;
   logic [DBits-1:0]         cdev;
   logic                     outlier;
   logic [SAMPLE_BITS-1:0]   new_val;

   // radius from the window register, forced odd and clamped
   always_comb begin
      logic [4:0] w;
      w = win_ff | 5'd1;
      if (w < 5'd3) w = 5'd3;
      if (32'(w) > WMax) w = 5'(WMax);
      rad  = IdxBits'(w >> 1);
      nwin = IdxBits'({rad, 1'b1});
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 5'd7;
         k_ff   <= 16'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            hdf_pkg::CsrWindow: win_ff <= csr_data[4:0];
            hdf_pkg::CsrK:      win_ff <= win_ff;
            default:            win_ff <= win_ff;
         endcase
         if (csr_index == hdf_pkg::CsrK) k_ff <= csr_data;
      end
   end

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == hdf_pkg::ST_IDLE) && !run_ff && (pos_ff <= rad);
   assign pending = last_ff ? (pos_ff < seen_ff) : ((seen_ff - pos_ff) > rad);
   assign is_last_bin = last_ff && (pos_ff + IdxBits'(1) == seen_ff);
   assign centre = hist_ff[pos_ff[PosBits-1:0]];
   // old history goes only when a word is offered or a bin is due
   assign drop = (state_ff == hdf_pkg::ST_IDLE) && (pos_ff > rad)
                 && (run_ff ? pending : req_tvalid);
   assign mid_cell = cell_val[rad[PosBits-1:0]];

   // window gather with edge replication
   always_comb begin
      for (int t = 0; t < MAX_WINDOW; t++) begin
         int idx;
         idx = int'(pos_ff) - int'(rad) + t;
         if (idx < 0) idx = 0;
         if (idx > int'(seen_ff) - 1) idx = int'(seen_ff) - 1;
         cell_load[t] = {hist_ff[idx[PosBits-1:0]][SAMPLE_BITS-1],
                         hist_ff[idx[PosBits-1:0]]};
         cell_dev[t] = ($signed(cell_val[t]) >= $signed(mid_cell))
            ? cell_val[t] - mid_cell : mid_cell - cell_val[t];
      end
   end

   assign ctl.load = (state_ff == hdf_pkg::ST_LOAD);
   assign ctl.sort = (state_ff == hdf_pkg::ST_SORT) || (state_ff == hdf_pkg::ST_SORT2);
   assign ctl.odd  = phase_ff[0];
   assign ctl.dev  = (state_ff == hdf_pkg::ST_DEV);

   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      hdf_sort_cell #(.DataBits(DBits)) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .active_phase ((g % 2) == (ctl.odd ? 1 : 0)),
         .is_unsigned  (state_ff == hdf_pkg::ST_SORT2),
         .load_value   (cell_load[g]),
         .dev_value    (cell_dev[g]),
         .left_value   (cell_val[(g == 0) ? 0 : g - 1]),
         .right_value  (cell_val[(g == MAX_WINDOW - 1) ? g : g + 1]),
         .has_left     (g != 0 && IdxBits'(g) < nwin),
         .has_right    (IdxBits'(g + 1) < nwin),
         .left_phase   (((g - 1) % 2) == (ctl.odd ? 1 : 0)),
         .value        (cell_val[g])
      );
   end

   always_comb begin
      logic [DBits-1:0] cm;
      cm = {med_ff[SAMPLE_BITS-1], med_ff};
      cdev = ($signed({centre[SAMPLE_BITS-1], centre}) >= $signed(cm))
         ? {centre[SAMPLE_BITS-1], centre} - cm : cm - {centre[SAMPLE_BITS-1], centre};
   end
   assign outlier = lhs_ff > thr_ff;
   assign new_val = outlier ? med_ff : centre;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hdf_pkg::ST_IDLE:
            if (run_ff && pending && pos_ff <= rad) state_in = hdf_pkg::ST_LOAD;
         hdf_pkg::ST_LOAD:  state_in = hdf_pkg::ST_SORT;
         hdf_pkg::ST_SORT:  if (phase_ff + IdxBits'(1) == nwin) state_in = hdf_pkg::ST_DEV;
         hdf_pkg::ST_DEV:   state_in = hdf_pkg::ST_SORT2;
         hdf_pkg::ST_SORT2: if (phase_ff + IdxBits'(1) == nwin) state_in = hdf_pkg::ST_TEST;
         hdf_pkg::ST_TEST:  if (!out_valid_ff || rsp_tready) state_in = hdf_pkg::ST_EMIT;
         hdf_pkg::ST_EMIT:  state_in = hdf_pkg::ST_IDLE;
         default:           state_in = hdf_pkg::ST_IDLE;
      endcase
   end

   // datapath and bookkeeping
   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      run_in   = run_ff;
      case (state_ff)
         hdf_pkg::ST_LOAD:  phase_in = '0;
         hdf_pkg::ST_SORT:  phase_in = (state_in == hdf_pkg::ST_SORT) ? phase_ff + IdxBits'(1) : '0;
         hdf_pkg::ST_SORT2: phase_in = phase_ff + IdxBits'(1);
         hdf_pkg::ST_EMIT: begin
            pos_in = pos_ff + IdxBits'(1);
            if (is_last_bin) begin
               seen_in = '0;
               pos_in  = '0;
               last_in = 1'b0;
            end
         end
         default: ;
      endcase
      if (drop) begin
         seen_in = seen_ff - IdxBits'(1);
         pos_in  = pos_ff - IdxBits'(1);
      end else if (accept) begin
         last_in = req_tlast;
         if (32'(seen_ff) >= MAX_WINDOW) begin
            pos_in = pos_ff - IdxBits'(1);
         end else begin
            seen_in = seen_ff + IdxBits'(1);
         end
      end
      if (accept) begin
         run_in = 1'b1;
      end else if (state_ff == hdf_pkg::ST_IDLE && !pending) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hdf_pkg::ST_IDLE;
         seen_ff      <= '0;
         pos_ff       <= '0;
         last_ff      <= 1'b0;
         run_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         run_ff   <= run_in;
         seen_ff  <= seen_in;
         pos_ff   <= pos_in;
         if (state_ff == hdf_pkg::ST_EMIT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         // drop excess left history before taking a new bin or filtering
         if (drop) begin
            for (int i = 0; i < MAX_WINDOW - 1; i++) hist_ff[i] <= hist_ff[i + 1];
         end else if (accept) begin
            if (32'(seen_ff) >= MAX_WINDOW) begin
               for (int i = 0; i < MAX_WINDOW - 1; i++) hist_ff[i] <= hist_ff[i + 1];
               hist_ff[MAX_WINDOW - 1] <= req_tdata;
            end else begin
               hist_ff[seen_ff[PosBits-1:0]] <= req_tdata;
            end
         end else if (state_ff == hdf_pkg::ST_EMIT) begin
            hist_ff[pos_ff[PosBits-1:0]] <= new_val;
         end
      end
   end

   // accept is blocked while excess history is pending
   always_ff @(posedge clock) begin
      if (state_ff == hdf_pkg::ST_DEV) med_ff <= mid_cell[SAMPLE_BITS-1:0];
      if (state_ff == hdf_pkg::ST_LOAD) begin
         kmul_ff <= KsBits'(k_ff) * KsBits'(hdf_pkg::SigmaQ16);
      end
      // mad sits in the middle cell here
      if (state_ff == hdf_pkg::ST_TEST) begin
         lhs_ff <= ProdBits'(cdev) << 24;
         thr_ff <= ProdBits'(kmul_ff) * ProdBits'(mid_cell);
      end
      if (state_ff == hdf_pkg::ST_EMIT) begin
         out_data_ff <= new_val;
         out_rep_ff  <= outlier;
         out_last_ff <= is_last_bin;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_rep_ff;
   assign rsp_tlast  = out_last_ff;

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset)
         (state_ff != hdf_pkg::ST_IDLE) |-> !req_tready;
   endproperty
   assert property (p_no_accept_busy) else $error("accept while busy");

   property p_pos_le_seen;
      @(posedge clock) disable iff (reset) pos_ff <= seen_ff;
   endproperty
   assert property (p_pos_le_seen) else $error("output position past fill");
endmodule
`default_nettype wire

// ===== tb/sv/hampel_despike_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hampel_despike_filter_checker
// Watches the sample, result and register channels of the despike filter,
// keeps its own copy of the bin history, predicts every filtered bin and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module hampel_despike_filter_checker #(
   parameter int unsigned MAX_WINDOW  = 17,
   parameter int unsigned SAMPLE_BITS = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   input  wire                    req_tready,
   input  wire [SAMPLE_BITS-1:0]  req_tdata,
   input  wire                    req_tlast,
   input  wire                    rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire [SAMPLE_BITS-1:0]  rsp_tdata,
   input  wire                    rsp_tuser,
   input  wire                    rsp_tlast,
   input  wire                    csr_valid,
   input  wire                    csr_ready,
   input  wire [0:0]              csr_index,
   input  wire [15:0]             csr_data,
   output int                     fail_count,
   output int                     pending_bins
);
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] value;
      logic                   replaced;
      logic                   last;
   } filtered_bin_type;

   filtered_bin_type expected_bins[$];
   logic signed [63:0] history[MAX_WINDOW];
   int unsigned held_count;
   int unsigned emit_pos;
   logic [4:0]  win_reg;
   logic [15:0] k_reg;

   assign pending_bins = expected_bins.size();

   function automatic int unsigned half_width();
      int unsigned w;
      int unsigned wmax;
      w = win_reg | 5'd1;
      wmax = (MAX_WINDOW - 1) | 1;
      if (w < 3) w = 3;
      if (w > wmax) w = wmax;
      return w / 2;
   endfunction

   task automatic shift_history();
      for (int i = 0; i < MAX_WINDOW - 1; i++) history[i] = history[i + 1];
      held_count--;
      emit_pos--;
   endtask

   function automatic logic [63:0] abs_gap(logic signed [63:0] a, logic signed [63:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic filter_bin(int unsigned r, logic last);
      logic signed [63:0] win[MAX_WINDOW];
      logic signed [63:0] srt[MAX_WINDOW];
      logic [63:0] dev[MAX_WINDOW];
      logic signed [63:0] med;
      logic signed [63:0] centre;
      logic signed [63:0] tmp;
      logic [63:0] utmp;
      logic [63:0] mad;
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic outlier;
      int n;
      int idx;
      filtered_bin_type fb;
      n = 2 * r + 1;
      for (int t = 0; t < n; t++) begin
         idx = int'(emit_pos) - int'(r) + t;
         if (idx < 0) idx = 0;
         if (idx > int'(held_count) - 1) idx = held_count - 1;
         win[t] = history[idx];
         srt[t] = win[t];
      end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n - 1 - i; j++)
            if (srt[j] > srt[j + 1]) begin
               tmp = srt[j]; srt[j] = srt[j + 1]; srt[j + 1] = tmp;
            end
      med = srt[r];
      for (int t = 0; t < n; t++) dev[t] = abs_gap(win[t], med);
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n - 1 - i; j++)
            if (dev[j] > dev[j + 1]) begin
               utmp = dev[j]; dev[j] = dev[j + 1]; dev[j + 1] = utmp;
            end
      mad = dev[r];
      centre = history[emit_pos];
      lhs = {64'd0, abs_gap(centre, med)} << 24;
      rhs = 128'(k_reg) * 128'(hdf_pkg::SigmaQ16) * 128'(mad);
      outlier = lhs > rhs;
      if (outlier) history[emit_pos] = med;
      fb.value = outlier ? med[SAMPLE_BITS-1:0] : centre[SAMPLE_BITS-1:0];
      fb.replaced = outlier;
      fb.last = last;
      expected_bins.push_back(fb);
      emit_pos++;
   endtask

   task automatic take_bin(logic [SAMPLE_BITS-1:0] raw, logic last);
      int unsigned r;
      r = half_width();
      while (emit_pos > r) shift_history();
      if (held_count >= MAX_WINDOW) shift_history();
      history[held_count] = 64'(signed'(raw));
      held_count++;
      if (last) begin
         while (emit_pos < held_count) begin
            while (emit_pos > r) shift_history();
            filter_bin(r, emit_pos + 1 == held_count);
         end
         held_count = 0;
         emit_pos = 0;
      end else begin
         while (held_count - emit_pos > r) begin
            while (emit_pos > r) shift_history();
            filter_bin(r, 1'b0);
         end
      end
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("error: %s got %0h expected %0h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      filtered_bin_type want;
      if (reset) begin
         expected_bins.delete();
         held_count = 0;
         emit_pos = 0;
         win_reg = 5'd7;
         k_reg = 16'd1024;
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == hdf_pkg::CsrWindow) win_reg = csr_data[4:0];
            else k_reg = csr_data;
         end
         // result first: a word produced this edge cannot be checked yet
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bins.size() == 0) begin
               report("unexpected word", rsp_tdata, 0);
            end else begin
               want = expected_bins.pop_front();
               if (rsp_tdata !== want.value) report("sample_out", rsp_tdata, want.value);
               if (rsp_tuser !== want.replaced) report("replaced", rsp_tuser, want.replaced);
               if (rsp_tlast !== want.last) report("last_out", rsp_tlast, want.last);
            end
         end
         if (req_tvalid && req_tready) take_bin(req_tdata, req_tlast);
      end
   end
endmodule

// ===== tb/sv/tb_hampel_despike_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hampel_despike_filter_unit
// Drives spectra through the despike filter under several window and
// threshold settings with random stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_hampel_despike_filter_unit;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // sample_in
   logic        req_tlast = 1'b0; // last_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // sample_out
   logic        rsp_tuser;        // replaced
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = hdf_pkg::CsrWindow;
   logic [15:0] csr_data = '0;
   int          fail_count;
   int          pending_bins;
   bit          steady = 1'b0;

   always #2 clock = ~clock;

   hampel_despike_filter_unit u_top (.*);

   hampel_despike_filter_checker u_check (.*);

   // random ready with about 11 percent idle, none during the steady stretch
   always @(posedge clock) rsp_tready <= steady || ($urandom_range(99) >= 11);

   task automatic write_reg(logic [0:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_bin(logic [31:0] value, logic last);
      while (!steady && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_bins != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample(logic [31:0] base);
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return base + $urandom_range(40000, 5000);
         default: return base + $urandom_range(20) - 10;
      endcase
   endfunction

   task automatic send_spectrum(int len, int windowed_change);
      logic [31:0] base;
      base = $urandom();
      for (int i = 0; i < len; i++) begin
         if (windowed_change != 0 && i == len / 2) begin
            req_tvalid <= 1'b0;
            drain();
            write_reg(hdf_pkg::CsrWindow, 16'($urandom_range(31)));
         end
         send_bin(pick_sample(base), i == len - 1);
      end
   endtask

   logic [15:0] win_set[8] = '{16'd3, 16'd17, 16'd7, 16'd4, 16'd0, 16'd31, 16'd5, 16'd11};
   logic [15:0] k_set[8] = '{16'd1024, 16'd0, 16'hffff, 16'd256, 16'd512, 16'd3000,
                             16'd1, 16'd768};

   initial begin
      int sent;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, short spectra, a lone spike, a one-bin spectrum
      send_bin(32'h7fffffff, 1'b0);
      send_bin(32'h80000000, 1'b0);
      send_bin(32'h00000000, 1'b0);
      send_bin(32'hffffffff, 1'b1);
      send_bin(32'h12345678, 1'b1);
      for (int i = 0; i < 12; i++)
         send_bin((i == 6) ? 32'h40000000 : 32'd100 + i, i == 11);
      send_bin(32'd5, 1'b0);
      send_bin(32'd5, 1'b1);
      drain();
      sent = 0;
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(hdf_pkg::CsrWindow, win_set[phase]);
         write_reg(hdf_pkg::CsrK, k_set[phase]);
         steady = (phase == 3);
         for (int s = 0; s < 4; s++) begin
            int len;
            len = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
            send_spectrum(len, (s == 2) ? 1 : 0);
            sent += len;
         end
         steady = 1'b0;
         drain();
      end
      write_reg(hdf_pkg::CsrK, 16'($urandom()));
      while (sent < 480) begin
         int len;
         len = $urandom_range(16, 1);
         send_spectrum(len, 0);
         sent += len;
      end
      drain();
      if (fail_count == 0) begin
         $display("hampel_despike_filter_unit: match");
      end else begin
         $display("hampel_despike_filter_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("hampel_despike_filter_unit: mismatch");
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/hdf_pkg.sv
hdl/hdf_sort_cell.sv
hdl/hampel_despike_filter_unit.sv
tb/sv/hampel_despike_filter_checker.sv
tb/sv/tb_hampel_despike_filter_unit.sv
